// ===== design/feel_pkg.sv =====
// Shared types and fixed widths for the field-aware embedding lookup.
package feel_pkg;

	localparam int unsigned DATA_W    = 16;
	localparam int unsigned FRAC_W    = 12;
	localparam int unsigned SUM_W     = 32;
	localparam int unsigned IDX_W     = 4;
	localparam int unsigned OFFSET_W  = 11;
	localparam int unsigned WADDR_W   = 32;
	localparam int unsigned BADDR_W   = 18;
	localparam int unsigned QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		REQ_WR_WEIGHT = 2'd0,
		REQ_WR_BIAS   = 2'd1,
		REQ_WR_OFFSET = 2'd2,
		REQ_LOOKUP    = 2'd3
	} req_t;

	typedef struct packed {
		req_t                 req;
		logic                 bad;
		logic [WADDR_W-1:0]   waddr;
		logic [BADDR_W-1:0]   baddr;
		logic [DATA_W-1:0]    data;
	} cmd_t;

endpackage

// ===== design/field_aware_embedding_lookup_core.sv =====
// A lookup passes front s1, s2 and the queue, then back s1 (RAM read), s2 and output reg.
// A lookup holds the back end for EMBED elements, one weight RAM read a cycle when not stalled.
// Weight and bias writes are done when the back end pops them; offset writes finish at acceptance.
// A 4-entry command queue lets the front end take requests while results stall.
// Reset clears control state and the offset valid bits; no RAM clearing pass is run.
module field_aware_embedding_lookup_core #(
	parameter int unsigned FIELDS = 8,
	parameter int unsigned EMBED = 16,
	parameter int unsigned FEATURE_ROWS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [16:0]         write_addr,
	input  logic signed [15:0]  write_data,
	input  logic [2:0]          src_field,
	input  logic [2:0]          dst_field,
	input  logic [9:0]          feature_id,
	input  logic signed [15:0]  sample_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          elem_index,
	output logic signed [31:0]  product_sum,
	output logic                row_error,
	output logic                last_elem
);

	logic           f_valid;
	logic           f_ready;
	feel_pkg::cmd_t f_cmd;
	logic           b_valid;
	logic           b_ready;
	feel_pkg::cmd_t b_cmd;

	feel_front #(
		.FIELDS(FIELDS),
		.EMBED(EMBED),
		.FEATURE_ROWS(FEATURE_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.write_addr(write_addr),
		.write_data(write_data),
		.src_field(src_field),
		.dst_field(dst_field),
		.feature_id(feature_id),
		.sample_value(sample_value),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd(f_cmd)
	);

	feel_queue #(
		.DEPTH(feel_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data(f_cmd),
		.pop_valid(b_valid),
		.pop_ready(b_ready),
		.pop_data(b_cmd)
	);

	feel_back #(
		.FIELDS(FIELDS),
		.EMBED(EMBED),
		.FEATURE_ROWS(FEATURE_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd(b_cmd),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.elem_index(elem_index),
		.product_sum(product_sum),
		.row_error(row_error),
		.last_elem(last_elem)
	);

endmodule

// ===== design/feel_ram.sv =====
// Generic simple dual-port RAM with registered read.
module feel_ram #(
	parameter int unsigned WIDTH = 16,
	parameter longint unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/feel_front.sv =====
// Front end: accepts requests, keeps the field offset table, resolves rows and addresses.
module feel_front #(
	parameter int unsigned FIELDS = 8,
	parameter int unsigned EMBED = 16,
	parameter int unsigned FEATURE_ROWS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [16:0]         write_addr,
	input  logic signed [15:0]  write_data,
	input  logic [2:0]          src_field,
	input  logic [2:0]          dst_field,
	input  logic [9:0]          feature_id,
	input  logic signed [15:0]  sample_value,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output feel_pkg::cmd_t      cmd
);

	localparam int unsigned OFF_DEPTH = FIELDS + 1;
	localparam int unsigned OAW = $clog2(OFF_DEPTH);
	localparam int unsigned RW = (FEATURE_ROWS > 1) ? $clog2(FEATURE_ROWS) : 1;
	localparam int unsigned ROW_W = feel_pkg::OFFSET_W + 1;
	localparam longint unsigned WDEPTH = longint'(FEATURE_ROWS) * longint'(FIELDS) *
		longint'(EMBED);
	localparam int unsigned BDEPTH = FIELDS * FIELDS * EMBED;
	localparam int unsigned FE = FIELDS * EMBED;

	feel_pkg::req_t req_in;
	logic accept;
	logic off_we;
	logic [OAW-1:0] off_widx;
	logic [OAW-1:0] off_ridx;
	logic [feel_pkg::OFFSET_W-1:0] off_rdata;
	logic [OFF_DEPTH-1:0] off_valid_q;
	logic adv;

	logic v_s1;
	feel_pkg::req_t req_s1;
	logic [16:0] addr_s1;
	logic [feel_pkg::DATA_W-1:0] data_s1;
	logic [2:0] src_s1;
	logic [2:0] dst_s1;
	logic [9:0] fid_s1;
	logic offv_s1;

	logic [ROW_W-1:0] row_sum;
	logic lookup_bad;
	logic bad_d;

	logic v_s2;
	feel_pkg::req_t req_s2;
	logic bad_s2;
	logic [RW-1:0] row_s2;
	logic [16:0] addr_s2;
	logic [feel_pkg::DATA_W-1:0] data_s2;
	logic [2:0] src_s2;
	logic [2:0] dst_s2;

	logic [31:0] wl_addr;
	logic [31:0] bl_addr;

	assign req_in   = feel_pkg::req_t'(req_type);
	assign accept   = in_valid && in_ready;
	assign off_we   = accept && (req_in == feel_pkg::REQ_WR_OFFSET) &&
		(32'(write_addr) < OFF_DEPTH);
	assign off_widx = OAW'(write_addr);
	assign off_ridx = OAW'(src_field);

	feel_ram #(
		.WIDTH(feel_pkg::OFFSET_W),
		.DEPTH(OFF_DEPTH)
	) u_offset_ram (
		.clk(clk),
		.we(off_we),
		.waddr(off_widx),
		.wdata(write_data[feel_pkg::OFFSET_W-1:0]),
		.re(accept),
		.raddr(off_ridx),
		.rdata(off_rdata)
	);

	assign adv       = !v_s2 || cmd_ready;
	assign in_ready  = !v_s1 || adv;
	assign cmd_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			off_valid_q <= '0;
		end else begin
			if (in_ready) begin
				v_s1 <= accept && (req_in != feel_pkg::REQ_WR_OFFSET);
			end
			if (adv) begin
				v_s2 <= v_s1;
			end
			if (off_we) begin
				off_valid_q[off_widx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req_in;
			addr_s1 <= write_addr;
			data_s1 <= (req_in == feel_pkg::REQ_LOOKUP) ? sample_value : write_data;
			src_s1  <= src_field;
			dst_s1  <= dst_field;
			fid_s1  <= feature_id;
			offv_s1 <= (32'(src_field) < OFF_DEPTH) && off_valid_q[off_ridx];
		end
		if (adv && v_s1) begin
			req_s2  <= req_s1;
			bad_s2  <= bad_d;
			row_s2  <= lookup_bad ? '0 : RW'(row_sum);
			addr_s2 <= addr_s1;
			data_s2 <= data_s1;
			src_s2  <= src_s1;
			dst_s2  <= dst_s1;
		end
	end

	always_comb begin
		row_sum = ROW_W'(fid_s1) + (offv_s1 ? ROW_W'(off_rdata) : '0);
		lookup_bad = (32'(src_s1) >= FIELDS) || (32'(dst_s1) >= FIELDS) ||
			(32'(row_sum) >= FEATURE_ROWS);
		case (req_s1)
			feel_pkg::REQ_WR_WEIGHT: bad_d = !(64'(addr_s1) < WDEPTH);
			feel_pkg::REQ_WR_BIAS:   bad_d = !(32'(addr_s1) < BDEPTH);
			default:                 bad_d = lookup_bad;
		endcase
	end

	always_comb begin
		wl_addr = 32'(row_s2) * 32'(FE) + 32'(dst_s2) * 32'(EMBED);
		bl_addr = 32'(src_s2) * 32'(FE) + 32'(dst_s2) * 32'(EMBED);
		cmd.req  = req_s2;
		cmd.bad  = bad_s2;
		cmd.data = data_s2;
		case (req_s2)
			feel_pkg::REQ_LOOKUP: begin
				cmd.waddr = bad_s2 ? '0 : wl_addr;
				cmd.baddr = bad_s2 ? '0 : bl_addr[feel_pkg::BADDR_W-1:0];
			end
			default: begin
				cmd.waddr = 32'(addr_s2);
				cmd.baddr = feel_pkg::BADDR_W'(addr_s2);
			end
		endcase
	end

endmodule

// ===== design/feel_queue.sv =====
// Command queue between the front end and the back end.
module feel_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  feel_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output feel_pkg::cmd_t pop_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	feel_pkg::cmd_t entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/feel_back.sv =====
// Back end: weight and bias stores, element sequencer and multiply-add pipeline.
module feel_back #(
	parameter int unsigned FIELDS = 8,
	parameter int unsigned EMBED = 16,
	parameter int unsigned FEATURE_ROWS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  feel_pkg::cmd_t      cmd,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          elem_index,
	output logic signed [31:0]  product_sum,
	output logic                row_error,
	output logic                last_elem
);

	localparam longint unsigned WDEPTH = longint'(FEATURE_ROWS) * longint'(FIELDS) *
		longint'(EMBED);
	localparam longint unsigned BDEPTH = longint'(FIELDS) * longint'(FIELDS) * longint'(EMBED);
	localparam int unsigned WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
	localparam int unsigned BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int unsigned EW = (EMBED > 1) ? $clog2(EMBED) : 1;
	localparam int unsigned EXT_W = feel_pkg::SUM_W - feel_pkg::DATA_W - feel_pkg::FRAC_W;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic [EW-1:0] e_q;
	logic [WAW-1:0] wbase_q;
	logic [BAW-1:0] bbase_q;
	logic bad_q;
	logic [feel_pkg::DATA_W-1:0] val_q;

	logic en;
	logic issue;
	logic issue_last;
	logic pop;
	logic w_we;
	logic b_we;
	logic [WAW-1:0] w_raddr;
	logic [BAW-1:0] b_raddr;
	logic [feel_pkg::DATA_W-1:0] w_rdata;
	logic [feel_pkg::DATA_W-1:0] b_rdata;

	logic v_s1;
	logic [EW-1:0] idx_s1;
	logic last_s1;
	logic bad_s1;
	logic [feel_pkg::DATA_W-1:0] val_s1;

	logic v_s2;
	logic signed [feel_pkg::SUM_W-1:0] prod_s2;
	logic [feel_pkg::DATA_W-1:0] bias_s2;
	logic [EW-1:0] idx_s2;
	logic last_s2;
	logic bad_s2;

	logic out_valid_q;
	logic signed [feel_pkg::SUM_W-1:0] sum_q;
	logic [feel_pkg::IDX_W-1:0] idx_q;
	logic last_q;
	logic err_q;
	logic [feel_pkg::SUM_W-1:0] bias_ext;

	assign en         = !out_valid_q || out_ready;
	assign issue      = (state_q == ST_RUN) && en;
	assign issue_last = issue && (e_q == EW'(EMBED - 1));
	assign cmd_ready  = (state_q == ST_IDLE) || issue_last;
	assign pop        = cmd_valid && cmd_ready;
	assign w_we       = pop && (cmd.req == feel_pkg::REQ_WR_WEIGHT) && !cmd.bad;
	assign b_we       = pop && (cmd.req == feel_pkg::REQ_WR_BIAS) && !cmd.bad;
	assign w_raddr    = wbase_q + WAW'(e_q);
	assign b_raddr    = bbase_q + BAW'(e_q);

	feel_ram #(
		.WIDTH(feel_pkg::DATA_W),
		.DEPTH(WDEPTH)
	) u_weight_ram (
		.clk(clk),
		.we(w_we),
		.waddr(cmd.waddr[WAW-1:0]),
		.wdata(cmd.data),
		.re(issue),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	feel_ram #(
		.WIDTH(feel_pkg::DATA_W),
		.DEPTH(BDEPTH)
	) u_bias_ram (
		.clk(clk),
		.we(b_we),
		.waddr(cmd.baddr[BAW-1:0]),
		.wdata(cmd.data),
		.re(issue),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q     <= '0;
			wbase_q <= '0;
			bbase_q <= '0;
			bad_q   <= 1'b0;
			val_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (cmd.req == feel_pkg::REQ_LOOKUP)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue) begin
						e_q <= issue_last ? '0 : e_q + 1'b1;
					end
					if (issue_last && !(pop && (cmd.req == feel_pkg::REQ_LOOKUP))) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (pop && (cmd.req == feel_pkg::REQ_LOOKUP)) begin
				e_q     <= '0;
				wbase_q <= cmd.waddr[WAW-1:0];
				bbase_q <= cmd.baddr[BAW-1:0];
				bad_q   <= cmd.bad;
				val_q   <= cmd.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign bias_ext = {{EXT_W{bias_s2[feel_pkg::DATA_W-1]}}, bias_s2,
		{feel_pkg::FRAC_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= e_q;
			last_s1 <= (e_q == EW'(EMBED - 1));
			bad_s1  <= bad_q;
			val_s1  <= val_q;
		end
		if (en && v_s1) begin
			prod_s2 <= $signed(w_rdata) * $signed(val_s1);
			bias_s2 <= b_rdata;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			bad_s2  <= bad_s1;
		end
		if (en && v_s2) begin
			sum_q  <= bad_s2 ? '0 : prod_s2 + $signed(bias_ext);
			idx_q  <= feel_pkg::IDX_W'(idx_s2);
			last_q <= last_s2;
			err_q  <= bad_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign elem_index  = idx_q;
	assign product_sum = sum_q;
	assign row_error   = err_q;
	assign last_elem   = last_q;

endmodule

// ===== design/feel_checker.sv =====
// Port-level checker for the embedding lookup core and its bind.
module feel_checker #(
	parameter int unsigned EMBED = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [3:0]         elem_index,
	input logic signed [31:0] product_sum,
	input logic               row_error,
	input logic               last_elem
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(product_sum) &&
		$stable(elem_index) && $stable(row_error) && $stable(last_elem))
		else $error("result changed while stalled");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_elem |-> elem_index == feel_pkg::IDX_W'(EMBED - 1))
		else $error("last element flagged at wrong index");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_error |-> product_sum == '0)
		else $error("row error with nonzero result");

	a_next_elem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_elem |=> !out_valid ||
		(elem_index == feel_pkg::IDX_W'($past(elem_index) + 4'd1) &&
		row_error == $past(row_error)))
		else $error("element sequence broken within a lookup");

endmodule

bind field_aware_embedding_lookup_core feel_checker #(
	.EMBED(EMBED)
) u_feel_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.elem_index(elem_index),
	.product_sum(product_sum),
	.row_error(row_error),
	.last_elem(last_elem)
);
